// ===== hdl/hebbian_link_neuron_tick_core_macros.svh =====
// Assertion shorthands for the link/neuron tick core.
`ifndef HEBBIAN_LINK_NEURON_TICK_CORE_MACROS_SVH
`define HEBBIAN_LINK_NEURON_TICK_CORE_MACROS_SVH

// Clocked check, switched off while reset is held.
`define HLNT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define HLNT_CHECK_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hlnt_pkg.sv =====
package hlnt_pkg;

    localparam int LINKS_DEF   = 512;
    localparam int NEURONS_DEF = 32;
    localparam int PADDR_W     = 5;

    typedef enum logic [1:0] {
        REQ_LINK  = 2'd0,
        REQ_FORCE = 2'd1,
        REQ_TICK  = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        REG_BURST  = 3'd0,
        REG_REST   = 3'd1,
        REG_THRESH = 3'd2,
        REG_STRIKE = 3'd3,
        REG_SPONT  = 3'd4,
        REG_GSTART = 3'd5,
        REG_GSTEP  = 3'd6,
        REG_SEED   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FORCE,
        ST_LWALK,
        ST_LFLUSH,
        ST_NWALK,
        ST_NFLUSH
    } state_t;

    localparam logic [15:0] BURST_RST  = 16'd100;
    localparam logic [15:0] REST_RST   = 16'd100;
    localparam logic [15:0] THRESH_RST = 16'd5;
    localparam logic [19:0] STRIKE_RST = 20'd10486;
    localparam logic [6:0]  GSTART_RST = 7'd50;
    localparam logic [6:0]  GSTEP_RST  = 7'd1;
    localparam logic [19:0] SEED_RST   = 20'd1;

    localparam logic [6:0] GROWTH_MAX = 7'd100;
    localparam logic [6:0] ON_LEVEL   = 7'd90;
    localparam logic [6:0] OFF_LEVEL  = 7'd10;

    typedef struct packed {
        logic       used;
        logic [5:0] src;
        logic [5:0] dst;
        logic       neg;
        logic [6:0] growth;
        logic       on;
    } link_word_t;

    typedef struct packed {
        logic [31:0]        stamp;
        logic signed [15:0] acc;
    } neuron_word_t;

    // x^20 + x^17 + 1, shift left, feedback into bit 0
    function automatic logic [19:0] lfsr_adv(input logic [19:0] s);
        return {s[18:0], s[19] ^ s[16]};
    endfunction

endpackage

// ===== hdl/hlnt_ram.sv =====
module hlnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/hebbian_link_neuron_tick_core.sv =====
// Link write and unused request are answered straight from idle; neuron force after
// the force state (straight from idle if the output would not change or the index is
// out of range); tick after the link walk, then the neuron walk (one entry per cycle,
// a flush state after each). One item at a time, the next taken as its result shows;
// results cannot be stalled. Reset: async, active low. Then a clearing pass over all
// LINKS entries empties the link table (busy high); config writes are taken throughout.
module hebbian_link_neuron_tick_core #(
    parameter int LINKS   = hlnt_pkg::LINKS_DEF,
    parameter int NEURONS = hlnt_pkg::NEURONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [8:0]  link_index,
    input  logic        link_valid,
    input  logic [5:0]  src_neuron,
    input  logic [5:0]  dst_neuron,
    input  logic        link_negative,
    input  logic [5:0]  neuron_index,
    input  logic        neuron_value,
    output logic        done,
    output logic [63:0] active_mask,
    output logic [31:0] tick_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [hlnt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LAW = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int NAW = $clog2(NEURONS);
    localparam logic [LAW-1:0] L_LAST = LAW'(LINKS - 1);
    localparam logic [NAW-1:0] N_LAST = NAW'(NEURONS - 1);
    localparam logic [6:0]     N_LIM  = 7'(NEURONS);
    localparam logic [12:0]    L_LIM  = 13'(LINKS);
    localparam int LWW = $bits(hlnt_pkg::link_word_t);
    localparam int NWW = $bits(hlnt_pkg::neuron_word_t);

    hlnt_pkg::state_t state_reg, state_next;

    logic [LAW-1:0] lcnt_reg, lcnt_next;
    logic [LAW-1:0] s1_idx_reg, s1_idx_next;
    logic           s1_v_reg, s1_v_next;
    logic           s2_v_reg, s2_v_next;
    logic           s2_neg_reg, s2_neg_next;
    logic [NAW-1:0] ncnt_reg, ncnt_next;
    logic           sn_v_reg, sn_v_next;
    logic [NAW-1:0] nrd_addr_reg, nrd_addr_next;
    logic           fwd_v_reg, fwd_v_next;
    logic [NAW-1:0] fwd_addr_reg, fwd_addr_next;
    hlnt_pkg::neuron_word_t fwd_data_reg, fwd_data_next;
    logic [NEURONS-1:0] nvalid_reg, nvalid_next;
    logic           fval_reg, fval_next;

    logic [63:0] fires_reg, fires_next;
    logic [31:0] step_reg, step_next;
    logic [19:0] lfsr_reg, lfsr_next;

    logic        done_reg, done_next;
    logic [63:0] mask_reg, mask_next;
    logic [31:0] tick_reg, tick_next;

    logic [15:0]        burst_reg, burst_next;
    logic [15:0]        rest_reg, rest_next;
    logic signed [15:0] thr_reg, thr_next;
    logic [19:0]        strike_reg, strike_next;
    logic               spont_reg, spont_next;
    logic [6:0]         gstart_reg, gstart_next;
    logic [6:0]         gstep_reg, gstep_next;
    logic [19:0]        seed_reg, seed_next;

    logic                 l_we;
    logic [LAW-1:0]       l_waddr, l_raddr;
    hlnt_pkg::link_word_t l_wdata;
    logic [LWW-1:0]       l_rdata;

    logic                   n_we;
    logic [NAW-1:0]         n_waddr, n_raddr;
    hlnt_pkg::neuron_word_t n_wdata;
    logic [NWW-1:0]         n_rdata;

    logic cfg_we;

    hlnt_ram #(.WIDTH(LWW), .DEPTH(LINKS)) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    hlnt_ram #(.WIDTH(NWW), .DEPTH(NEURONS)) u_neuron_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (hlnt_pkg::reg_idx_t'(paddr[4:2]))
            hlnt_pkg::REG_BURST:  prdata = {16'd0, burst_reg};
            hlnt_pkg::REG_REST:   prdata = {16'd0, rest_reg};
            hlnt_pkg::REG_THRESH: prdata = {16'd0, thr_reg};
            hlnt_pkg::REG_STRIKE: prdata = {12'd0, strike_reg};
            hlnt_pkg::REG_SPONT:  prdata = {31'd0, spont_reg};
            hlnt_pkg::REG_GSTART: prdata = {25'd0, gstart_reg};
            hlnt_pkg::REG_GSTEP:  prdata = {25'd0, gstep_reg};
            hlnt_pkg::REG_SEED:   prdata = {12'd0, seed_reg};
            default:              prdata = '0;
        endcase
    end

    always_comb
    begin
        hlnt_pkg::link_word_t   lw;
        hlnt_pkg::neuron_word_t n_seen;
        hlnt_pkg::neuron_word_t w;
        logic                   sa, da, fire;
        logic signed [8:0]      gs, st;
        logic [6:0]             g7;
        logic [31:0]            age;
        logic [12:0]            li_ext;
        logic [19:0]            draw;

        state_next    = state_reg;
        lcnt_next     = lcnt_reg;
        s1_idx_next   = lcnt_reg;
        s1_v_next     = 1'b0;
        s2_v_next     = 1'b0;
        s2_neg_next   = s2_neg_reg;
        ncnt_next     = ncnt_reg;
        sn_v_next     = 1'b0;
        nrd_addr_next = nrd_addr_reg;
        nvalid_next   = nvalid_reg;
        fval_next     = fval_reg;
        fires_next    = fires_reg;
        step_next     = step_reg;
        lfsr_next     = lfsr_reg;
        done_next     = 1'b0;
        mask_next     = mask_reg;
        tick_next     = tick_reg;

        burst_next  = burst_reg;
        rest_next   = rest_reg;
        thr_next    = thr_reg;
        strike_next = strike_reg;
        spont_next  = spont_reg;
        gstart_next = gstart_reg;
        gstep_next  = gstep_reg;
        seed_next   = seed_reg;

        l_we    = 1'b0;
        l_waddr = s1_idx_reg;
        l_wdata = '0;
        l_raddr = lcnt_reg;
        n_we    = 1'b0;
        n_waddr = nrd_addr_reg;
        n_wdata = '0;
        n_raddr = nrd_addr_reg;

        lw     = l_rdata;
        li_ext = 13'(link_index);
        sa     = 1'b0;
        da     = 1'b0;
        fire   = 1'b0;
        gs     = '0;
        st     = '0;
        g7     = '0;
        age    = '0;
        draw   = '0;

        // forward the last neuron write: the RAM returns old data on a collision
        if (fwd_v_reg && fwd_addr_reg == nrd_addr_reg)
        begin
            n_seen = fwd_data_reg;
        end
        else if (nvalid_reg[nrd_addr_reg])
        begin
            n_seen = n_rdata;
        end
        else
        begin
            n_seen = '0;
        end
        w = n_seen;

        // link stage: growth update and input request
        if (s1_v_reg && lw.used)
        begin
            sa = (7'(lw.src) < N_LIM) && fires_reg[lw.src];
            da = (7'(lw.dst) < N_LIM) && fires_reg[lw.dst];
            if (lw.on && sa && (7'(lw.dst) < N_LIM))
            begin
                n_raddr       = NAW'(lw.dst);
                nrd_addr_next = NAW'(lw.dst);
                s2_v_next     = 1'b1;
                s2_neg_next   = lw.neg;
            end
            gs = $signed({2'b00, lw.growth});
            st = $signed({2'b00, gstep_reg});
            if (sa && da)
            begin
                gs = lw.neg ? gs - st : gs + st;
            end
            else if (sa || da)
            begin
                gs = lw.neg ? gs + st : gs - st;
            end
            if (gs < 0)
            begin
                g7 = '0;
            end
            else if (gs > $signed({2'b00, hlnt_pkg::GROWTH_MAX}))
            begin
                g7 = hlnt_pkg::GROWTH_MAX;
            end
            else
            begin
                g7 = gs[6:0];
            end
            l_wdata        = lw;
            l_wdata.growth = g7;
            if (g7 > hlnt_pkg::ON_LEVEL)
            begin
                l_wdata.on = 1'b1;
            end
            else if (g7 < hlnt_pkg::OFF_LEVEL)
            begin
                l_wdata.on = 1'b0;
            end
            l_we    = 1'b1;
            l_waddr = s1_idx_reg;
        end

        // saturating input accumulate
        if (s2_v_reg)
        begin
            if (s2_neg_reg)
            begin
                if (w.acc != 16'sh8000)
                begin
                    w.acc = w.acc - 16'sd1;
                end
            end
            else if (w.acc != 16'sh7FFF)
            begin
                w.acc = w.acc + 16'sd1;
            end
            n_we    = 1'b1;
            n_wdata = w;
        end

        // neuron stage: burst end, rest end, firing
        if (sn_v_reg)
        begin
            age = step_reg - w.stamp;
            if (fires_reg[nrd_addr_reg])
            begin
                if (age > {16'd0, burst_reg})
                begin
                    fires_next[nrd_addr_reg] = 1'b0;
                    w.stamp = step_reg;
                end
            end
            else if (age > {16'd0, rest_reg})
            begin
                if (spont_reg)
                begin
                    draw      = hlnt_pkg::lfsr_adv(lfsr_reg);
                    lfsr_next = draw;
                    fire      = draw < strike_reg;
                end
                if ($signed(w.acc) > thr_reg)
                begin
                    fire = 1'b1;
                end
                if (fire)
                begin
                    fires_next[nrd_addr_reg] = 1'b1;
                    w.stamp = step_reg;
                end
                w.acc = '0;
            end
            n_we    = 1'b1;
            n_wdata = w;
        end

        unique case (state_reg)
            hlnt_pkg::ST_CLEAR:
            begin
                l_we    = 1'b1;
                l_waddr = lcnt_reg;
                l_wdata = '0;
                if (lcnt_reg == L_LAST)
                begin
                    lcnt_next  = '0;
                    state_next = hlnt_pkg::ST_IDLE;
                end
                else
                begin
                    lcnt_next = lcnt_reg + 1'b1;
                end
            end
            hlnt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        hlnt_pkg::REQ_LINK:
                        begin
                            if (li_ext < L_LIM)
                            begin
                                l_we           = 1'b1;
                                l_waddr        = li_ext[LAW-1:0];
                                l_wdata.used   = link_valid;
                                l_wdata.src    = src_neuron;
                                l_wdata.dst    = dst_neuron;
                                l_wdata.neg    = link_negative;
                                l_wdata.growth = (gstart_reg > hlnt_pkg::GROWTH_MAX) ?
                                                 hlnt_pkg::GROWTH_MAX : gstart_reg;
                                l_wdata.on     = 1'b0;
                            end
                            done_next = 1'b1;
                        end
                        hlnt_pkg::REQ_FORCE:
                        begin
                            if ((7'(neuron_index) < N_LIM) &&
                                (fires_reg[neuron_index] != neuron_value))
                            begin
                                n_raddr       = NAW'(neuron_index);
                                nrd_addr_next = NAW'(neuron_index);
                                fval_next     = neuron_value;
                                state_next    = hlnt_pkg::ST_FORCE;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        hlnt_pkg::REQ_TICK:
                        begin
                            lcnt_next  = '0;
                            state_next = hlnt_pkg::ST_LWALK;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            hlnt_pkg::ST_FORCE:
            begin
                w.stamp = step_reg;
                n_we    = 1'b1;
                n_wdata = w;
                fires_next[nrd_addr_reg] = fval_reg;
                done_next  = 1'b1;
                state_next = hlnt_pkg::ST_IDLE;
            end
            hlnt_pkg::ST_LWALK:
            begin
                l_raddr     = lcnt_reg;
                s1_idx_next = lcnt_reg;
                s1_v_next   = 1'b1;
                if (lcnt_reg == L_LAST)
                begin
                    lcnt_next  = '0;
                    state_next = hlnt_pkg::ST_LFLUSH;
                end
                else
                begin
                    lcnt_next = lcnt_reg + 1'b1;
                end
            end
            hlnt_pkg::ST_LFLUSH:
            begin
                ncnt_next  = '0;
                state_next = hlnt_pkg::ST_NWALK;
            end
            hlnt_pkg::ST_NWALK:
            begin
                n_raddr       = ncnt_reg;
                nrd_addr_next = ncnt_reg;
                sn_v_next     = 1'b1;
                if (ncnt_reg == N_LAST)
                begin
                    ncnt_next  = '0;
                    state_next = hlnt_pkg::ST_NFLUSH;
                end
                else
                begin
                    ncnt_next = ncnt_reg + 1'b1;
                end
            end
            hlnt_pkg::ST_NFLUSH:
            begin
                step_next  = step_reg + 32'd1;
                done_next  = 1'b1;
                state_next = hlnt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = hlnt_pkg::ST_IDLE;
            end
        endcase

        if (n_we)
        begin
            nvalid_next[n_waddr] = 1'b1;
        end
        fwd_v_next    = n_we;
        fwd_addr_next = n_waddr;
        fwd_data_next = n_wdata;

        if (cfg_we)
        begin
            unique case (hlnt_pkg::reg_idx_t'(paddr[4:2]))
                hlnt_pkg::REG_BURST:  burst_next  = pwdata[15:0];
                hlnt_pkg::REG_REST:   rest_next   = pwdata[15:0];
                hlnt_pkg::REG_THRESH: thr_next    = $signed(pwdata[15:0]);
                hlnt_pkg::REG_STRIKE: strike_next = pwdata[19:0];
                hlnt_pkg::REG_SPONT:  spont_next  = pwdata[0];
                hlnt_pkg::REG_GSTART: gstart_next = pwdata[6:0];
                hlnt_pkg::REG_GSTEP:  gstep_next  = pwdata[6:0];
                hlnt_pkg::REG_SEED:
                begin
                    seed_next = pwdata[19:0];
                    lfsr_next = (pwdata[19:0] == 20'd0) ? 20'd1 : pwdata[19:0];
                end
                default:
                begin
                    seed_next = seed_reg;
                end
            endcase
        end

        if (done_next)
        begin
            mask_next = fires_next;
            tick_next = step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hlnt_pkg::ST_CLEAR;
            lcnt_reg     <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            ncnt_reg     <= '0;
            sn_v_reg     <= 1'b0;
            fwd_v_reg    <= 1'b0;
            nvalid_reg   <= '0;
            fires_reg    <= '0;
            step_reg     <= '0;
            lfsr_reg     <= hlnt_pkg::SEED_RST;
            done_reg     <= 1'b0;
            mask_reg     <= '0;
            tick_reg     <= '0;
            burst_reg    <= hlnt_pkg::BURST_RST;
            rest_reg     <= hlnt_pkg::REST_RST;
            thr_reg      <= $signed(hlnt_pkg::THRESH_RST);
            strike_reg   <= hlnt_pkg::STRIKE_RST;
            spont_reg    <= 1'b1;
            gstart_reg   <= hlnt_pkg::GSTART_RST;
            gstep_reg    <= hlnt_pkg::GSTEP_RST;
            seed_reg     <= hlnt_pkg::SEED_RST;
        end
        else
        begin
            state_reg    <= state_next;
            lcnt_reg     <= lcnt_next;
            s1_v_reg     <= s1_v_next;
            s2_v_reg     <= s2_v_next;
            ncnt_reg     <= ncnt_next;
            sn_v_reg     <= sn_v_next;
            fwd_v_reg    <= fwd_v_next;
            nvalid_reg   <= nvalid_next;
            fires_reg    <= fires_next;
            step_reg     <= step_next;
            lfsr_reg     <= lfsr_next;
            done_reg     <= done_next;
            mask_reg     <= mask_next;
            tick_reg     <= tick_next;
            burst_reg    <= burst_next;
            rest_reg     <= rest_next;
            thr_reg      <= thr_next;
            strike_reg   <= strike_next;
            spont_reg    <= spont_next;
            gstart_reg   <= gstart_next;
            gstep_reg    <= gstep_next;
            seed_reg     <= seed_next;
        end
    end

    // payload only
    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= s1_idx_next;
        s2_neg_reg   <= s2_neg_next;
        nrd_addr_reg <= nrd_addr_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
        fval_reg     <= fval_next;
    end

    assign busy        = (state_reg != hlnt_pkg::ST_IDLE);
    assign done        = done_reg;
    assign active_mask = mask_reg;
    assign tick_count  = tick_reg;

endmodule

// ===== hdl/hlnt_checker.sv =====
`include "hebbian_link_neuron_tick_core_macros.svh"

module hlnt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  req_type,
    input logic        done,
    input logic [31:0] tick_count
);

    logic link_acc;
    logic tick_acc;

    assign link_acc = start && !busy && (req_type == hlnt_pkg::REQ_LINK);
    assign tick_acc = start && !busy && (req_type == hlnt_pkg::REQ_TICK);

    `HLNT_CHECK(a_done_idle, done |-> !busy, "result strobe while busy")
    `HLNT_CHECK(a_link_fast, link_acc |=> done, "link write item not answered next cycle")
    `HLNT_CHECK(a_tick_busy, tick_acc |=> busy, "tick item did not raise busy")
    `HLNT_CHECK(a_count_moves, !$stable(tick_count) |-> done, "tick count moved without a result")
    `HLNT_CHECK_NR(a_reset_quiet, !rst_n |=> !done, "result strobe out of reset")

endmodule

bind hebbian_link_neuron_tick_core hlnt_checker u_hlnt_checker (.*);
